FILE: rtl/dbsr_pkg.sv
// Shared types, constants and the octant-limit table of the disc brush span rasterizer.
// No dependencies.
package dbsr_pkg;

  localparam int IN_W   = 14;  // centre coordinate width, two's complement
  localparam int OUT_W  = 12;  // span row and column width
  localparam int RAD_W  = 5;   // radius register width
  localparam int CNV_W  = 13;  // canvas size register width
  localparam int IDX_W  = 5;   // row offset and column reach width (up to radius + 1)
  localparam int SQ_W   = 2 * IDX_W;  // width of a square of an offset
  localparam int ACC_W  = SQ_W + 2;   // signed width of the step unit's sum
  localparam int OFS_W  = 16;  // signed width of a centre plus or minus an offset

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam int DEF_MAX_CANVAS = 4096;
  localparam int DEF_MAX_RADIUS = 22;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [RAD_W-1:0] RST_RADIUS = RAD_W'(1);
  localparam logic [CNV_W-1:0] RST_WIDTH  = CNV_W'(4096);
  localparam logic [CNV_W-1:0] RST_HEIGHT = CNV_W'(4096);

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [CNV_W-1:0] width;
    logic [CNV_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] right;
    logic [OUT_W-1:0] left;
    logic [OUT_W-1:0] row;
  } span_t;

  // floor(r * 1000 / 1414), the last row offset of the first octant
  function automatic logic [IDX_W-1:0] octant_limit(input logic [RAD_W-1:0] r);
    logic [IDX_W-1:0] l;
    unique case (r)
      5'd0, 5'd1:          l = 5'd0;
      5'd2:                l = 5'd1;
      5'd3, 5'd4:          l = 5'd2;
      5'd5:                l = 5'd3;
      5'd6, 5'd7:          l = 5'd4;
      5'd8:                l = 5'd5;
      5'd9:                l = 5'd6;
      5'd10:               l = 5'd7;
      5'd11:               l = 5'd7;
      5'd12:               l = 5'd8;
      5'd13, 5'd14:        l = 5'd9;
      5'd15:               l = 5'd10;
      5'd16:               l = 5'd11;
      5'd17, 5'd18:        l = 5'd12;
      5'd19:               l = 5'd13;
      5'd20, 5'd21:        l = 5'd14;
      default:             l = 5'd15;
    endcase
    return l;
  endfunction

endpackage

FILE: rtl/dbsr_cfg.sv
// APB-style register file: brush radius and canvas size.
// Depends on dbsr_pkg.
module dbsr_cfg import dbsr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [RAD_W-1:0] radius_r;
  logic [CNV_W-1:0] width_r;
  logic [CNV_W-1:0] height_r;
  logic             wr_en;
  logic [1:0]       idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RST_RADIUS;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (wr_en) begin
      case (idx)
        REG_RADIUS: radius_r <= cfg_pwdata[RAD_W-1:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[CNV_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[CNV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS: cfg_prdata = CFG_DW'(radius_r);
      REG_WIDTH:  cfg_prdata = CFG_DW'(width_r);
      REG_HEIGHT: cfg_prdata = CFG_DW'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg.radius = radius_r;
  assign cfg.width  = width_r;
  assign cfg.height = height_r;

endmodule

FILE: rtl/dbsr_step.sv
// Shared step unit of the boundary search: evaluates i*i + (j-1)*(j-1) - r*r once per cycle.
// Depends on dbsr_pkg.
module dbsr_step import dbsr_pkg::*; (
  input  logic [IDX_W-1:0] i,
  input  logic [IDX_W-1:0] j,
  input  logic [SQ_W-1:0]  rr,
  output logic             shrink,
  output logic             ym_is_j
);

  logic [IDX_W-1:0]        jm1;
  logic [SQ_W-1:0]         si;
  logic [SQ_W-1:0]         sj;
  logic signed [ACC_W-1:0] g;
  logic signed [ACC_W-1:0] gj;

  assign jm1 = j - 1'b1;
  assign si  = {{IDX_W{1'b0}}, i} * {{IDX_W{1'b0}}, i};
  assign sj  = {{IDX_W{1'b0}}, jm1} * {{IDX_W{1'b0}}, jm1};
  assign g   = $signed({2'b00, si}) + $signed({2'b00, sj}) - $signed({2'b00, rr});
  // g + j - 1 equals f(j) - j, so ym stays at j when g + j is not positive
  assign gj  = g + $signed({{(ACC_W-IDX_W){1'b0}}, j});

  assign shrink  = (g > 0);
  assign ym_is_j = (gj <= 0);

endmodule

FILE: rtl/dbsr_clip.sv
// Span clipper: drops a span off the canvas and clamps its ends to the canvas width.
// Depends on dbsr_pkg.
module dbsr_clip import dbsr_pkg::*; (
  input  logic signed [OFS_W-1:0] lo,
  input  logic signed [OFS_W-1:0] hi,
  input  logic signed [OFS_W-1:0] row,
  input  logic [CNV_W-1:0]        w,
  input  logic [CNV_W-1:0]        h,
  output logic                    vis,
  output span_t                   span
);

  logic signed [OFS_W-1:0] ws;
  logic signed [OFS_W-1:0] hs;
  logic signed [OFS_W-1:0] wm1;

  assign ws  = $signed({{(OFS_W-CNV_W){1'b0}}, w});
  assign hs  = $signed({{(OFS_W-CNV_W){1'b0}}, h});
  assign wm1 = ws - 16'sd1;

  assign vis = (row >= 0) && (row < hs) && (lo < ws) && (hi >= 0);

  assign span.row   = row[OUT_W-1:0];
  assign span.left  = (lo < 0) ? '0 : lo[OUT_W-1:0];
  assign span.right = (hi >= ws) ? wm1[OUT_W-1:0] : hi[OUT_W-1:0];

endmodule

FILE: rtl/disc_brush_span_rasterizer_core.sv
// Disc brush span rasterizer top level: sequencer, span buffer and output register.
// Depends on dbsr_pkg, dbsr_cfg, dbsr_step and dbsr_clip.
//
// Usage: each word on the in_ channel is a brush centre (x, y). The block emits on the
// out_ channel the horizontal spans of a filled disc of the configured radius around it,
// clipped to the canvas, four spans per row offset of the first octant, in that order.
// The last visible span of a centre carries tlast; a centre whose spans are all clipped
// away produces no word. Radius and canvas size are set over the cfg_ port while idle.
// Flow: in_tready is high only while idle, so a new centre is taken only once the last
// one is done. A centre is worked through by the single step unit that walks the disc
// boundary one column a cycle, and by the single clipper that handles one span a cycle
// while the output side can take its spans.
// A span waits in a one-word buffer until the next visible span or the end of the centre
// shows whether it is the last. When the receiver stalls, the output register holds its
// word and the sequencer waits once the buffer is also full; nothing is dropped.
// Reset (rst_n, synchronous) empties the pipeline and restores radius 1, canvas 4096x4096.
module disc_brush_span_rasterizer_core import dbsr_pkg::*; #(
  parameter int MAX_CANVAS = DEF_MAX_CANVAS,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // center_x [13:0], center_y [27:14], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // span_row [11:0], span_left [23:12],
                                             // span_right [35:24], zero pad
  output logic                   out_tlast,  // last_span
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_EMIT, ST_FLUSH} state_t;

  cfg_t cfg;

  state_t                 state_r;
  logic [1:0]             k_r;
  logic [IDX_W-1:0]       i_r;
  logic [IDX_W-1:0]       j_r;
  logic [IDX_W-1:0]       ym_r;
  logic [IDX_W-1:0]       lim_r;
  logic [SQ_W-1:0]        rr_r;
  logic signed [IN_W-1:0] x_r;
  logic signed [IN_W-1:0] y_r;
  logic [CNV_W-1:0]       w_r;
  logic [CNV_W-1:0]       h_r;
  span_t                  pend_r;
  logic                   pend_v_r;
  span_t                  out_r;
  logic                   out_last_r;
  logic                   out_v_r;

  logic [RAD_W-1:0]        r_eff;
  logic [CNV_W:0]          max_cnv;
  logic [CNV_W-1:0]        w_eff;
  logic [CNV_W-1:0]        h_eff;
  logic                    shrink;
  logic                    ym_is_j;
  logic signed [OFS_W-1:0] xs;
  logic signed [OFS_W-1:0] ys;
  logic signed [OFS_W-1:0] di;
  logic signed [OFS_W-1:0] dy;
  logic signed [OFS_W-1:0] lo;
  logic signed [OFS_W-1:0] hi;
  logic signed [OFS_W-1:0] row;
  logic                    vis;
  span_t                   span;
  logic                    out_free;
  logic                    can_go;
  logic                    out_load;

  dbsr_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  // saturate the configuration to the design limits
  assign r_eff   = (cfg.radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg.radius;
  assign max_cnv = (CNV_W+1)'(MAX_CANVAS);
  assign w_eff   = ({1'b0, cfg.width} > max_cnv) ? max_cnv[CNV_W-1:0] : cfg.width;
  assign h_eff   = ({1'b0, cfg.height} > max_cnv) ? max_cnv[CNV_W-1:0] : cfg.height;

  dbsr_step u_step (
    .i      (i_r),
    .j      (j_r),
    .rr     (rr_r),
    .shrink (shrink),
    .ym_is_j(ym_is_j)
  );

  assign xs = OFS_W'(x_r);
  assign ys = OFS_W'(y_r);
  assign di = $signed({{(OFS_W-IDX_W){1'b0}}, i_r});
  assign dy = $signed({{(OFS_W-IDX_W){1'b0}}, ym_r});

  always_comb begin
    unique case (k_r)
      2'd0: begin lo = xs - di; hi = xs + di; row = ys - dy; end
      2'd1: begin lo = xs - di; hi = xs + di; row = ys + dy; end
      2'd2: begin lo = xs - dy; hi = xs + dy; row = ys - di; end
      2'd3: begin lo = xs - dy; hi = xs + dy; row = ys + di; end
    endcase
  end

  dbsr_clip u_clip (
    .lo  (lo),
    .hi  (hi),
    .row (row),
    .w   (w_r),
    .h   (h_r),
    .vis (vis),
    .span(span)
  );

  assign out_free = !out_v_r || out_tready;
  // a visible span needs the buffer emptied into a free output register
  assign can_go   = !vis || !pend_v_r || out_free;
  assign out_load = ((state_r == ST_EMIT) && can_go && vis && pend_v_r) ||
                    ((state_r == ST_FLUSH) && pend_v_r && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_v_r && out_tready && !out_load) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            x_r     <= in_tdata[IN_W-1:0];
            y_r     <= in_tdata[2*IN_W-1:IN_W];
            rr_r    <= {{IDX_W{1'b0}}, r_eff} * {{IDX_W{1'b0}}, r_eff};
            lim_r   <= octant_limit(r_eff);
            i_r     <= '0;
            j_r     <= IDX_W'(r_eff) + 1'b1;
            w_r     <= w_eff;
            h_r     <= h_eff;
            state_r <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // walk the boundary column inward until the previous column is inside
          if (shrink) begin
            j_r <= j_r - 1'b1;
          end else begin
            ym_r    <= ym_is_j ? j_r : j_r - 1'b1;
            k_r     <= 2'd0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_go) begin
            if (vis) begin
              if (pend_v_r) begin
                out_r      <= pend_r;
                out_last_r <= 1'b0;
                out_v_r    <= 1'b1;
              end
              pend_r   <= span;
              pend_v_r <= 1'b1;
            end
            if (k_r == 2'd3) begin
              if (i_r == lim_r) begin
                state_r <= ST_FLUSH;
              end else begin
                i_r     <= i_r + 1'b1;
                state_r <= ST_SEARCH;
              end
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_r      <= pend_r;
            out_last_r <= 1'b1;
            out_v_r    <= 1'b1;
            pend_v_r   <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W-3*OUT_W){1'b0}}, out_r.right, out_r.left, out_r.row};

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_v_r)
    else $error("span buffer still full while idle");

  a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (j_r != '0 && i_r <= lim_r))
    else $error("boundary search out of range");

  a_pend_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_v_r) |-> ($past(state_r) == ST_EMIT))
    else $error("span buffer filled outside span emission");

endmodule
